@@ hw/rtl/ksl_pkg.sv @@
// ----------------------------------------------------------------------------
// ksl_pkg
// Shared constants and types for the keyed stack lookup table.
// ----------------------------------------------------------------------------
package ksl_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 8;
    localparam int VAL_W = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;
    localparam logic [1:0] ACT_DELETE = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    // Search request that travels one cell per cycle along the row.
    typedef struct packed {
        logic             active;
        logic             is_del;
        logic [KEY_W-1:0] key;
        logic             found;
        logic [VAL_W-1:0] value;
    } probe_t;

endpackage

@@ hw/rtl/ksl_cell.sv @@
// ----------------------------------------------------------------------------
// ksl_cell
// One storage slot of the table with its stage of the search pipeline.
// ----------------------------------------------------------------------------
module ksl_cell
    import ksl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             live,
    input  logic             ins_we,
    input  logic [KEY_W-1:0] ins_key,
    input  logic [VAL_W-1:0] ins_value,
    input  probe_t           probe_in,
    input  logic             up_shift,
    input  logic [KEY_W-1:0] up_key,
    input  logic [VAL_W-1:0] up_value,
    output probe_t           probe_out,
    output logic             shift_out,
    output logic [KEY_W-1:0] key_out,
    output logic [VAL_W-1:0] value_out
);

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    probe_t           probe_reg;
    logic             hit;

    always_ff @(posedge clk)
    begin
        if (ins_we)
        begin
            key_reg   <= ins_key;
            value_reg <= ins_value;
        end
        else if (up_shift)
        begin
            key_reg   <= up_key;
            value_reg <= up_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_in;
        end
    end

    // Only the oldest live match counts; later cells see found already set.
    assign hit = probe_reg.active && live && !probe_reg.found && (probe_reg.key == key_reg);

    always_comb
    begin
        probe_out       = probe_reg;
        probe_out.found = probe_reg.found | hit;
        if (hit)
        begin
            probe_out.value = value_reg;
        end
    end

    // Once a delete has matched below, every live entry above moves down one slot.
    assign shift_out = probe_reg.active && probe_reg.is_del && probe_reg.found && live;
    assign key_out   = key_reg;
    assign value_out = value_reg;

endmodule

@@ hw/rtl/keyed_stack_lookup_table_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_stack_lookup_table_unit
// Sixteen-entry key/value stack with insert, lookup, pop and delete by key.
// ----------------------------------------------------------------------------
// Insert and pop need no search: the result strobe (done) rises in the
// cycle after start is taken and busy stays low. Lookup and delete send the
// key down the row of DEPTH cells, one cell per cycle, and the result is
// registered once the key has left the last cell, with busy high until the
// last cell has been passed. Each result is shown for exactly one cycle with
// done high and must be captured then; it cannot be held off.
module keyed_stack_lookup_table_unit
    import ksl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              action,
    input  logic [KEY_W-1:0]        key,
    input  logic signed [VAL_W-1:0] value,
    output logic                    done,
    output logic signed [VAL_W-1:0] read_value,
    output logic                    found,
    output logic [1:0]              status
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VAL_W-1:0] read_value_reg, read_value_next;
    logic             found_reg, found_next;
    logic [1:0]       status_reg, status_next;

    logic   accept;
    logic   is_full;
    logic   is_empty;
    probe_t probe_head;

    probe_t           probe_chain [DEPTH+1];
    logic             shift_chain [DEPTH+1];
    logic [KEY_W-1:0] key_chain   [DEPTH+1];
    logic [VAL_W-1:0] value_chain [DEPTH+1];

    assign accept   = start && !busy_reg;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        probe_head        = '0;
        probe_head.active = accept && ((action == ACT_LOOKUP) || (action == ACT_DELETE));
        probe_head.is_del = (action == ACT_DELETE);
        probe_head.key    = key;
    end

    assign probe_chain[0]     = probe_head;
    assign shift_chain[DEPTH] = 1'b0;
    assign key_chain[DEPTH]   = '0;
    assign value_chain[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic cell_live;
        logic cell_we;
        logic cell_shift;

        assign cell_live = (CNT_W'(i) < count_reg);
        assign cell_we   = accept && (action == ACT_INSERT) && (count_reg == CNT_W'(i));

        ksl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .live      (cell_live),
            .ins_we    (cell_we),
            .ins_key   (key),
            .ins_value (value),
            .probe_in  (probe_chain[i]),
            .up_shift  (shift_chain[i+1]),
            .up_key    (key_chain[i+1]),
            .up_value  (value_chain[i+1]),
            .probe_out (probe_chain[i+1]),
            .shift_out (cell_shift),
            .key_out   (key_chain[i]),
            .value_out (value_chain[i])
        );

        assign shift_chain[i] = cell_shift;
    end

    always_comb
    begin
        count_next      = count_reg;
        busy_next       = busy_reg;
        done_next       = 1'b0;
        read_value_next = '0;
        found_next      = 1'b0;
        status_next     = ST_OK;

        if (accept)
        begin
            case (action)
                ACT_INSERT:
                begin
                    done_next = 1'b1;
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_POP:
                begin
                    done_next = 1'b1;
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b1;
                end
            endcase
        end

        // The search leaves the last cell: report it and settle the count.
        if (probe_chain[DEPTH].active)
        begin
            busy_next  = 1'b0;
            done_next  = 1'b1;
            found_next = probe_chain[DEPTH].found;
            if (probe_chain[DEPTH].is_del)
            begin
                if (probe_chain[DEPTH].found)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_ABSENT;
                end
            end
            else if (probe_chain[DEPTH].found)
            begin
                read_value_next = probe_chain[DEPTH].value;
            end
            else
            begin
                read_value_next = '1;
                status_next     = ST_ABSENT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign found      = found_reg;
    assign status     = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_scan_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg && ((action == ACT_LOOKUP) || (action == ACT_DELETE)))
        |=> busy_reg)
        else $error("search transfer did not raise busy");

    a_tail_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        probe_chain[DEPTH].active |-> busy_reg)
        else $error("search finished while idle");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (status_reg == ST_OK))
        else $error("match reported with error status");

    a_done_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
        probe_chain[DEPTH].active |=> (done_reg && !busy_reg))
        else $error("search result not delivered");

endmodule
